### hw/rtl/sme_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stack machine executor package
// Shared widths, opcodes, status codes, state types and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int PC_W   = 13;
  localparam int WORD_W = 64;
  localparam int OP_W   = 5;
  localparam int LID_W  = 8;
  localparam int POS_W  = 12;
  localparam int ST_W   = 3;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_HEAP_WORDS  = 1024;
  localparam int DEF_LABEL_COUNT = 256;
  localparam int DEF_CALL_DEPTH  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH     = 5'd0,
    OP_DUP      = 5'd1,
    OP_SWAP     = 5'd2,
    OP_DROP     = 5'd3,
    OP_ADD      = 5'd4,
    OP_SUB      = 5'd5,
    OP_MUL      = 5'd6,
    OP_DIV      = 5'd7,
    OP_MOD      = 5'd8,
    OP_STORE    = 5'd9,
    OP_RETRIEVE = 5'd10,
    OP_LABEL    = 5'd11,
    OP_CALL     = 5'd12,
    OP_JMP      = 5'd13,
    OP_JZ       = 5'd14,
    OP_JN       = 5'd15,
    OP_RET      = 5'd16,
    OP_END      = 5'd17,
    OP_PRINTC   = 5'd18,
    OP_PRINTI   = 5'd19,
    OP_READC    = 5'd20,
    OP_READI    = 5'd21
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_HEAP  = 3'd4,
    ST_CALL  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DEC, S_RDA, S_RDB, S_EXEC, S_SWAP2, S_MDWAIT, S_HEAPRD, S_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {MS_IDLE, MS_MUL, MS_DIV, MS_FIX} md_state_t;
  typedef enum logic [1:0] {MD_MUL, MD_DIV, MD_MOD} md_op_t;

  typedef enum logic [1:0] {WA_PUSH, WA_TOP, WA_SECOND} wr_addr_t;
  typedef enum logic [2:0] {WD_IMM, WD_READ, WD_A, WD_B, WD_ALU, WD_MD, WD_HEAP} wr_data_t;
  typedef enum logic [1:0] {SP_HOLD, SP_INC, SP_DEC, SP_DEC2} sp_op_t;
  typedef enum logic [1:0] {RC_HOLD, RC_INC, RC_DEC} rc_op_t;
  typedef enum logic [1:0] {PC_INC, PC_LABEL, PC_RET, PC_PLEN} pc_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     clr_en;
    logic     rd_second;
    logic     lat_a;
    logic     lat_b;
    logic     wr_en;
    wr_addr_t wr_addr;
    wr_data_t wr_data;
    sp_op_t   sp_op;
    rc_op_t   rc_op;
    logic     pc_en;
    pc_sel_t  pc_sel;
    logic     set_status;
    status_t  status;
    logic     print_en;
    logic     md_start;
    logic     heap_wr;
    logic     label_wr;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            in_valid;
    logic            sp_zero;
    logic            sp_lt2;
    logic            sp_full;
    logic            rc_zero;
    logic            rc_full;
    logic            a_zero;
    logic            a_neg;
    logic            a_heap_ok;
    logic            b_heap_ok;
    logic            md_done;
    logic            clr_done;
    logic            out_busy;
  } sts_t;

endpackage
`default_nettype wire

### hw/rtl/sme_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stack machine executor channels
// Valid/ready channels for instructions, results and the configuration write.
// ----------------------------------------------------------------------------
interface sme_in_if import sme_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [WORD_W-1:0] immediate;
  logic [LID_W-1:0]         label_id;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] read_value;
  modport source (output valid, opcode, immediate, label_id, position, read_value,
                  input ready);
  modport sink (input valid, opcode, immediate, label_id, position, read_value,
                output ready);
endinterface

interface sme_out_if import sme_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PC_W-1:0]          next_pc;
  logic                     print_valid;
  logic                     print_is_char;
  logic signed [WORD_W-1:0] print_value;
  logic                     halted;
  logic [ST_W-1:0]          status;
  modport source (output valid, next_pc, print_valid, print_is_char, print_value,
                  halted, status, input ready);
  modport sink (input valid, next_pc, print_valid, print_is_char, print_value,
                halted, status, output ready);
endinterface

interface sme_cfg_if import sme_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PC_W-1:0] program_length;
  modport source (output valid, program_length, input ready);
  modport sink (input valid, program_length, output ready);
endinterface
`default_nettype wire

### hw/rtl/stack_machine_executor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stack machine executor
// Executes one stack-machine instruction per input transaction.
// ----------------------------------------------------------------------------
// Channels: in_ch carries one instruction per transaction, out_ch returns one
// result (next pc, print, halted, status) per instruction, and cfg_ch writes
// program_length; it is always ready. The user must write program_length only
// while the block is idle; the block itself does not enforce this. An
// instruction is taken only in the idle state, one at a time. Multiply, divide
// and modulo wait for the multiply/divide unit, whose divider produces one
// quotient bit per cycle. The operand stack RAM has one read and one write
// port, so two-operand operations pass through S_RDB for the second read, swap
// through S_SWAP2 for its second write, and retrieve through S_HEAPRD to wait
// for the heap read. The next instruction can be taken in the cycle after the
// result is loaded into the output register. After reset the heap and label
// table are cleared by a sweep over max(HEAP_WORDS, LABEL_COUNT) addresses
// (1024 by default) before the first instruction is accepted. A stalled
// receiver holds the result register; an instruction already accepted
// completes and waits for it to drain.
// ----------------------------------------------------------------------------
module stack_machine_executor import sme_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int HEAP_WORDS  = DEF_HEAP_WORDS,
  parameter int LABEL_COUNT = DEF_LABEL_COUNT,
  parameter int CALL_DEPTH  = DEF_CALL_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sme_in_if.sink    in_ch,
  sme_out_if.source out_ch,
  sme_cfg_if.sink   cfg_ch
);

  cmd_t cmd;
  sts_t sts;

  sme_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .sts(sts), .cmd(cmd)
  );

  sme_dp #(
    .STACK_DEPTH(STACK_DEPTH),
    .HEAP_WORDS(HEAP_WORDS),
    .LABEL_COUNT(LABEL_COUNT),
    .CALL_DEPTH(CALL_DEPTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .cmd(cmd), .sts(sts)
  );

endmodule
`default_nettype wire

### hw/rtl/sme_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/sme_md.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stack machine multiply/divide unit
// Multiply in four 64x16 partial-product steps; signed divide and modulo by
// restoring division, one quotient bit per cycle, with a final sign fix.
// ----------------------------------------------------------------------------
module sme_md import sme_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire md_op_t            op,
  input  wire logic [WORD_W-1:0] a,
  input  wire logic [WORD_W-1:0] b,
  output logic                   done_r,
  output logic [WORD_W-1:0]      res_r
);

  md_state_t         state_r;
  md_op_t            op_r;
  logic [6:0]        cnt_r;
  logic [WORD_W-1:0] acc_r, mc_r, mp_r, quo_r, dvs_r;
  logic [WORD_W:0]   rem_r;
  logic              neg_q_r, neg_r_r;
  logic [WORD_W+15:0] prod;
  logic [WORD_W:0]   rem_sh;
  logic              ge;

  assign prod   = mc_r * mp_r[15:0];
  assign rem_sh = {rem_r[WORD_W-1:0], quo_r[WORD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MS_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        MS_IDLE: begin
          if (start) begin
            op_r    <= op;
            cnt_r   <= '0;
            acc_r   <= '0;
            mc_r    <= b;
            mp_r    <= a;
            rem_r   <= '0;
            quo_r   <= b[WORD_W-1] ? (~b + 1'b1) : b;
            dvs_r   <= a[WORD_W-1] ? (~a + 1'b1) : a;
            neg_q_r <= a[WORD_W-1] ^ b[WORD_W-1];
            neg_r_r <= b[WORD_W-1];
            state_r <= (op == MD_MUL) ? MS_MUL : MS_DIV;
          end
        end
        MS_MUL: begin
          acc_r <= acc_r + prod[WORD_W-1:0];
          mc_r  <= mc_r << 16;
          mp_r  <= mp_r >> 16;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd3) begin
            state_r <= MS_FIX;
          end
        end
        MS_DIV: begin
          rem_r <= ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
          quo_r <= {quo_r[WORD_W-2:0], ge};
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(WORD_W - 1)) begin
            state_r <= MS_FIX;
          end
        end
        MS_FIX: begin
          unique case (op_r)
            MD_MUL:  res_r <= acc_r;
            MD_DIV:  res_r <= neg_q_r ? (~quo_r + 1'b1) : quo_r;
            default: res_r <= neg_r_r ? (~rem_r[WORD_W-1:0] + 1'b1) : rem_r[WORD_W-1:0];
          endcase
          done_r  <= 1'b1;
          state_r <= MS_IDLE;
        end
        default: state_r <= MS_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sme_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stack machine datapath
// Instruction and operand registers, stack/heap/label/return RAMs, the
// multiply/divide unit, the program counter and the result register.
// ----------------------------------------------------------------------------
module sme_dp import sme_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int HEAP_WORDS  = DEF_HEAP_WORDS,
  parameter int LABEL_COUNT = DEF_LABEL_COUNT,
  parameter int CALL_DEPTH  = DEF_CALL_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sme_in_if.sink      in_ch,
  sme_out_if.source   out_ch,
  sme_cfg_if.sink     cfg_ch,
  input  wire cmd_t   cmd,
  output sts_t        sts
);

  localparam int SIW   = $clog2(STACK_DEPTH);
  localparam int SPW   = $clog2(STACK_DEPTH + 1);
  localparam int HAW   = $clog2(HEAP_WORDS);
  localparam int LIW   = $clog2(LABEL_COUNT);
  localparam int RIW   = $clog2(CALL_DEPTH);
  localparam int RCW   = $clog2(CALL_DEPTH + 1);
  localparam int CLR_N = (HEAP_WORDS > LABEL_COUNT) ? HEAP_WORDS : LABEL_COUNT;
  localparam int CLW   = $clog2(CLR_N);

  logic [OP_W-1:0]   op_r;
  logic [WORD_W-1:0] imm_r, rdv_r, a_r, b_r, pval_r;
  logic [LID_W-1:0]  lid_r;
  logic [POS_W-1:0]  pos_r, lt_r;
  logic [PC_W-1:0]   rt_r, pc_r, plen_r;
  logic [SPW-1:0]    sp_r;
  logic [RCW-1:0]    rc_r;
  status_t           status_r;
  logic              pvalid_r, pchar_r;
  logic [CLW-1:0]    clr_r;

  logic              out_valid_r, out_pv_r, out_pch_r, out_halt_r;
  logic [PC_W-1:0]   out_pc_r;
  logic [WORD_W-1:0] out_pval_r;
  status_t           out_st_r;

  logic              in_fire, lid_ok;
  logic [PC_W-1:0]   pc_inc, pc_nxt;
  logic [WORD_W-1:0] alu, md_res, st_rdata, st_wdata, heap_rdata;
  logic [SIW-1:0]    st_raddr, st_waddr;
  logic [POS_W-1:0]  lbl_rdata;
  logic [PC_W-1:0]   ret_rdata;
  logic              md_done;
  md_op_t            md_op;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = cmd.in_ready;
  assign cfg_ch.ready = 1'b1;
  assign lid_ok      = 32'(lid_r) < LABEL_COUNT;
  assign pc_inc      = pc_r + PC_W'(1);
  assign alu         = (op_r == OP_SUB) ? (b_r - a_r) : (b_r + a_r);
  assign md_op       = (op_r == OP_MUL) ? MD_MUL : ((op_r == OP_DIV) ? MD_DIV : MD_MOD);

  // Operand stack.
  assign st_raddr = cmd.rd_second ? SIW'(sp_r - SPW'(2)) : SIW'(sp_r - SPW'(1));

  always_comb begin
    unique case (cmd.wr_addr)
      WA_PUSH:   st_waddr = SIW'(sp_r);
      WA_TOP:    st_waddr = SIW'(sp_r - SPW'(1));
      WA_SECOND: st_waddr = SIW'(sp_r - SPW'(2));
      default:   st_waddr = SIW'(sp_r);
    endcase
    unique case (cmd.wr_data)
      WD_IMM:  st_wdata = imm_r;
      WD_READ: st_wdata = rdv_r;
      WD_A:    st_wdata = a_r;
      WD_B:    st_wdata = b_r;
      WD_ALU:  st_wdata = alu;
      WD_MD:   st_wdata = md_res;
      WD_HEAP: st_wdata = heap_rdata;
      default: st_wdata = a_r;
    endcase
    unique case (cmd.pc_sel)
      PC_INC:   pc_nxt = pc_inc;
      PC_LABEL: pc_nxt = lid_ok ? PC_W'(lt_r) : '0;
      PC_RET:   pc_nxt = rt_r;
      PC_PLEN:  pc_nxt = plen_r;
      default:  pc_nxt = pc_inc;
    endcase
  end

  sme_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(cmd.wr_en), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata_r(st_rdata)
  );

  // Heap and label table share the clearing sweep after reset.
  sme_ram #(.WIDTH(WORD_W), .DEPTH(HEAP_WORDS)) u_heap (
    .clk(clk),
    .we(cmd.clr_en ? (32'(clr_r) < HEAP_WORDS) : cmd.heap_wr),
    .waddr(cmd.clr_en ? HAW'(clr_r) : HAW'(b_r)),
    .wdata(cmd.clr_en ? '0 : a_r),
    .raddr(HAW'(a_r)),
    .rdata_r(heap_rdata)
  );

  sme_ram #(.WIDTH(POS_W), .DEPTH(LABEL_COUNT)) u_label (
    .clk(clk),
    .we(cmd.clr_en ? (32'(clr_r) < LABEL_COUNT) : (cmd.label_wr && lid_ok)),
    .waddr(cmd.clr_en ? LIW'(clr_r) : LIW'(lid_r)),
    .wdata(cmd.clr_en ? '0 : pos_r),
    .raddr(LIW'(lid_r)),
    .rdata_r(lbl_rdata)
  );

  sme_ram #(.WIDTH(PC_W), .DEPTH(CALL_DEPTH)) u_ret (
    .clk(clk),
    .we(cmd.rc_op == RC_INC),
    .waddr(RIW'(rc_r)),
    .wdata(pc_inc),
    .raddr(RIW'(rc_r - RCW'(1))),
    .rdata_r(ret_rdata)
  );

  sme_md u_md (
    .clk(clk), .rst_n(rst_n), .start(cmd.md_start), .op(md_op),
    .a(a_r), .b(b_r), .done_r(md_done), .res_r(md_res)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      rc_r        <= '0;
      pc_r        <= '0;
      plen_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        plen_r <= cfg_ch.program_length;
      end
      if (cmd.clr_en) begin
        clr_r <= clr_r + CLW'(1);
      end
      unique case (cmd.sp_op)
        SP_INC:  sp_r <= sp_r + SPW'(1);
        SP_DEC:  sp_r <= sp_r - SPW'(1);
        SP_DEC2: sp_r <= sp_r - SPW'(2);
        default: sp_r <= sp_r;
      endcase
      unique case (cmd.rc_op)
        RC_INC:  rc_r <= rc_r + RCW'(1);
        RC_DEC:  rc_r <= rc_r - RCW'(1);
        default: rc_r <= rc_r;
      endcase
      if (cmd.pc_en) begin
        pc_r <= pc_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_ch.opcode;
      imm_r    <= in_ch.immediate;
      lid_r    <= in_ch.label_id;
      pos_r    <= in_ch.position;
      rdv_r    <= in_ch.read_value;
      status_r <= ST_OK;
      pvalid_r <= 1'b0;
      pchar_r  <= 1'b0;
      pval_r   <= '0;
    end
    if (cmd.lat_a) begin
      a_r  <= st_rdata;
      lt_r <= lbl_rdata;
      rt_r <= ret_rdata;
    end
    if (cmd.lat_b) begin
      b_r <= st_rdata;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.print_en) begin
      pvalid_r <= 1'b1;
      pchar_r  <= (op_r == OP_PRINTC);
      pval_r   <= a_r;
    end
    if (cmd.out_load) begin
      out_pc_r   <= pc_r;
      out_pv_r   <= pvalid_r;
      out_pch_r  <= pchar_r;
      out_pval_r <= pval_r;
      out_halt_r <= pc_r >= plen_r;
      out_st_r   <= status_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.next_pc       = out_pc_r;
  assign out_ch.print_valid   = out_pv_r;
  assign out_ch.print_is_char = out_pch_r;
  assign out_ch.print_value   = out_pval_r;
  assign out_ch.halted        = out_halt_r;
  assign out_ch.status        = out_st_r;

  always_comb begin
    sts.op        = op_r;
    sts.in_valid  = in_ch.valid;
    sts.sp_zero   = sp_r == '0;
    sts.sp_lt2    = sp_r < SPW'(2);
    sts.sp_full   = sp_r >= SPW'(STACK_DEPTH);
    sts.rc_zero   = rc_r == '0;
    sts.rc_full   = rc_r >= RCW'(CALL_DEPTH);
    sts.a_zero    = a_r == '0;
    sts.a_neg     = a_r[WORD_W-1];
    sts.a_heap_ok = a_r < WORD_W'(HEAP_WORDS);
    sts.b_heap_ok = b_r < WORD_W'(HEAP_WORDS);
    sts.md_done   = md_done;
    sts.clr_done  = clr_r == CLW'(CLR_N - 1);
    sts.out_busy  = out_valid_r && !out_ch.ready;
  end

  ap_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH))
    else $error("operand stack count beyond depth");

  ap_rc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rc_r <= RCW'(CALL_DEPTH))
    else $error("call stack count beyond depth");

  ap_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_ch.ready))
    else $error("result register overwritten while held");

  ap_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

  ap_clear_closed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_en |-> !in_fire)
    else $error("instruction accepted during clearing sweep");

endmodule
`default_nettype wire

### hw/rtl/sme_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stack machine controller
// Sequences each instruction: operand reads, checks, execution, result.
// ----------------------------------------------------------------------------
module sme_ctrl import sme_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  ctrl_state_t state_r, state_nxt;
  op_t         op;

  assign op = op_t'(sts.op);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_RDA;
      end
      S_RDA: begin
        cmd.lat_a = 1'b1;
        if (!sts.sp_lt2 && (op inside {OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
                                       OP_MOD, OP_STORE})) begin
          cmd.rd_second = 1'b1;
          state_nxt     = S_RDB;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_RDB: begin
        cmd.lat_b = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.pc_en  = 1'b1;
        cmd.pc_sel = PC_INC;
        state_nxt  = S_DONE;
        unique case (op) inside
          OP_PUSH, OP_READC, OP_READI: begin
            if (sts.sp_full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_OVER;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_addr = WA_PUSH;
              cmd.wr_data = (op == OP_PUSH) ? WD_IMM : WD_READ;
              cmd.sp_op   = SP_INC;
            end
          end
          OP_DUP: begin
            if (sts.sp_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_UNDER;
            end else if (sts.sp_full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_OVER;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_addr = WA_PUSH;
              cmd.wr_data = WD_A;
              cmd.sp_op   = SP_INC;
            end
          end
          OP_SWAP: begin
            if (sts.sp_lt2) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_UNDER;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_addr = WA_TOP;
              cmd.wr_data = WD_B;
              state_nxt   = S_SWAP2;
            end
          end
          OP_DROP: begin
            if (sts.sp_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_UNDER;
            end else begin
              cmd.sp_op = SP_DEC;
            end
          end
          OP_ADD, OP_SUB: begin
            if (sts.sp_lt2) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_UNDER;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_addr = WA_SECOND;
              cmd.wr_data = WD_ALU;
              cmd.sp_op   = SP_DEC;
            end
          end
          OP_MUL, OP_DIV, OP_MOD: begin
            if (sts.sp_lt2) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_UNDER;
            end else if (op != OP_MUL && sts.a_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_DIVZ;
            end else begin
              cmd.md_start = 1'b1;
              state_nxt    = S_MDWAIT;
            end
          end
          OP_STORE: begin
            if (sts.sp_lt2) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_UNDER;
            end else if (!sts.b_heap_ok) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_HEAP;
            end else begin
              cmd.heap_wr = 1'b1;
              cmd.sp_op   = SP_DEC2;
            end
          end
          OP_RETRIEVE: begin
            if (sts.sp_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_UNDER;
            end else if (!sts.a_heap_ok) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_HEAP;
            end else begin
              state_nxt = S_HEAPRD;
            end
          end
          OP_LABEL: begin
            cmd.label_wr = 1'b1;
          end
          OP_CALL: begin
            if (sts.rc_full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_CALL;
            end else begin
              cmd.rc_op  = RC_INC;
              cmd.pc_sel = PC_LABEL;
            end
          end
          OP_JMP: begin
            cmd.pc_sel = PC_LABEL;
          end
          OP_JZ, OP_JN: begin
            if (sts.sp_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_UNDER;
            end else begin
              cmd.sp_op = SP_DEC;
              if ((op == OP_JZ && sts.a_zero) || (op == OP_JN && sts.a_neg)) begin
                cmd.pc_sel = PC_LABEL;
              end
            end
          end
          OP_RET: begin
            if (sts.rc_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_CALL;
            end else begin
              cmd.rc_op  = RC_DEC;
              cmd.pc_sel = PC_RET;
            end
          end
          OP_END: begin
            cmd.pc_sel = PC_PLEN;
          end
          OP_PRINTC, OP_PRINTI: begin
            if (sts.sp_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_UNDER;
            end else begin
              cmd.print_en = 1'b1;
              cmd.sp_op    = SP_DEC;
            end
          end
          default: begin
          end
        endcase
      end
      S_SWAP2: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = WA_SECOND;
        cmd.wr_data = WD_A;
        state_nxt   = S_DONE;
      end
      S_MDWAIT: begin
        if (sts.md_done) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = WA_SECOND;
          cmd.wr_data = WD_MD;
          cmd.sp_op   = SP_DEC;
          state_nxt   = S_DONE;
        end
      end
      S_HEAPRD: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = WA_TOP;
        cmd.wr_data = WD_HEAP;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### sim/tb_stack_machine_executor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine executor testbench
// Drives instructions with random idling and a long result stall, predicts
// each result with a behavioral model of the stack machine, and compares
// every result field in order.
// ----------------------------------------------------------------------------
import sme_pkg::*;

class sme_scoreboard;
  typedef struct packed {
    logic [PC_W-1:0]   pc;
    logic              pv;
    logic              pc_char;
    logic [WORD_W-1:0] pval;
    logic              halted;
    logic [ST_W-1:0]   status;
  } result_t;

  logic [WORD_W-1:0] stack_mem[DEF_STACK_DEPTH];
  int                depth;
  logic [WORD_W-1:0] heap_mem[DEF_HEAP_WORDS];
  logic [POS_W-1:0]  labels[DEF_LABEL_COUNT];
  logic [PC_W-1:0]   returns[DEF_CALL_DEPTH];
  int                ret_depth;
  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   prog_len;
  result_t           pending[$];
  int                errors;

  function new();
    depth = 0; ret_depth = 0; pc = '0; prog_len = '0; errors = 0;
    foreach (heap_mem[i]) heap_mem[i] = '0;
    foreach (labels[i]) labels[i] = '0;
  endfunction

  function automatic logic [WORD_W-1:0] magnitude(logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? -v : v;
  endfunction

  function void note_instruction(logic [OP_W-1:0] opc, logic [WORD_W-1:0] imm,
                                 logic [LID_W-1:0] lid, logic [POS_W-1:0] pos,
                                 logic [WORD_W-1:0] rd);
    result_t r;
    logic [PC_W-1:0] nxt;
    logic [WORD_W-1:0] a, b, q, t;
    logic take;
    nxt = pc + 1'b1;
    r = '0;
    r.status = ST_OK;
    case (opc)
      OP_PUSH, OP_READC, OP_READI: begin
        if (depth >= DEF_STACK_DEPTH) r.status = ST_OVER;
        else begin
          stack_mem[depth] = (opc == OP_PUSH) ? imm : rd;
          depth++;
        end
      end
      OP_DUP: begin
        if (depth < 1) r.status = ST_UNDER;
        else if (depth >= DEF_STACK_DEPTH) r.status = ST_OVER;
        else begin
          stack_mem[depth] = stack_mem[depth-1];
          depth++;
        end
      end
      OP_SWAP: begin
        if (depth < 2) r.status = ST_UNDER;
        else begin
          t = stack_mem[depth-1];
          stack_mem[depth-1] = stack_mem[depth-2];
          stack_mem[depth-2] = t;
        end
      end
      OP_DROP: begin
        if (depth < 1) r.status = ST_UNDER;
        else depth--;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
        if (depth < 2) r.status = ST_UNDER;
        else begin
          a = stack_mem[depth-1];
          b = stack_mem[depth-2];
          if ((opc == OP_DIV || opc == OP_MOD) && a == 0) r.status = ST_DIVZ;
          else begin
            case (opc)
              OP_ADD: q = b + a;
              OP_SUB: q = b - a;
              OP_MUL: q = b * a;
              OP_DIV: begin
                q = magnitude(b) / magnitude(a);
                if (b[WORD_W-1] ^ a[WORD_W-1]) q = -q;
              end
              default: begin
                q = magnitude(b) % magnitude(a);
                if (b[WORD_W-1]) q = -q;
              end
            endcase
            stack_mem[depth-2] = q;
            depth--;
          end
        end
      end
      OP_STORE: begin
        if (depth < 2) r.status = ST_UNDER;
        else if (stack_mem[depth-2] >= WORD_W'(DEF_HEAP_WORDS)) r.status = ST_HEAP;
        else begin
          heap_mem[int'(stack_mem[depth-2])] = stack_mem[depth-1];
          depth -= 2;
        end
      end
      OP_RETRIEVE: begin
        if (depth < 1) r.status = ST_UNDER;
        else if (stack_mem[depth-1] >= WORD_W'(DEF_HEAP_WORDS)) r.status = ST_HEAP;
        else stack_mem[depth-1] = heap_mem[int'(stack_mem[depth-1])];
      end
      OP_LABEL: labels[lid] = pos;
      OP_CALL: begin
        if (ret_depth >= DEF_CALL_DEPTH) r.status = ST_CALL;
        else begin
          returns[ret_depth] = nxt;
          ret_depth++;
          nxt = PC_W'(labels[lid]);
        end
      end
      OP_JMP: nxt = PC_W'(labels[lid]);
      OP_JZ, OP_JN: begin
        if (depth < 1) r.status = ST_UNDER;
        else begin
          a = stack_mem[depth-1];
          take = (opc == OP_JZ) ? (a == 0) : a[WORD_W-1];
          depth--;
          if (take) nxt = PC_W'(labels[lid]);
        end
      end
      OP_RET: begin
        if (ret_depth < 1) r.status = ST_CALL;
        else begin
          ret_depth--;
          nxt = returns[ret_depth];
        end
      end
      OP_END: nxt = prog_len;
      OP_PRINTC, OP_PRINTI: begin
        if (depth < 1) r.status = ST_UNDER;
        else begin
          r.pv = 1'b1;
          r.pc_char = (opc == OP_PRINTC);
          r.pval = stack_mem[depth-1];
          depth--;
        end
      end
      default: ;
    endcase
    pc = nxt;
    r.pc = nxt;
    r.halted = (nxt >= prog_len);
    pending.push_back(r);
  endfunction

  function void check_result(result_t got);
    result_t exp_r;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("Unexpected result transaction: %p", got);
      return;
    end
    exp_r = pending.pop_front();
    if (got !== exp_r) begin
      errors++;
      if (errors <= 10) $display("Result mismatch: expected %p, got %p", exp_r, got);
    end
  endfunction
endclass

module tb_stack_machine_executor;
  localparam int HOLD_LEN = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sme_in_if  in_ch ();
  sme_out_if out_ch ();
  sme_cfg_if cfg_ch ();

  stack_machine_executor DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  sme_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_cycles = 0;
  int sent;

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cycles <= HOLD_LEN;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result({out_ch.next_pc, out_ch.print_valid, out_ch.print_is_char,
                          out_ch.print_value, out_ch.halted, out_ch.status});
  end

  task automatic send_instruction(op_t opc, logic [WORD_W-1:0] imm,
                                  logic [LID_W-1:0] lid, logic [POS_W-1:0] pos,
                                  logic [WORD_W-1:0] rd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= opc;
    in_ch.immediate <= imm;
    in_ch.label_id <= lid;
    in_ch.position <= pos;
    in_ch.read_value <= rd;
    do @(posedge clk); while (!in_ch.ready);
    board.note_instruction(opc, imm, lid, pos, rd);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_length(logic [PC_W-1:0] len);
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.program_length <= len;
    do @(posedge clk); while (!cfg_ch.ready);
    board.prog_len = len;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return {$urandom, $urandom};
      3: return -WORD_W'($urandom_range(40));
      default: return WORD_W'($urandom_range(40));
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_address();
    case ($urandom_range(7))
      0: return {$urandom, $urandom};
      1: return WORD_W'(DEF_HEAP_WORDS);
      2: return WORD_W'(DEF_HEAP_WORDS - 1);
      default: return WORD_W'($urandom_range(DEF_HEAP_WORDS - 1));
    endcase
  endfunction

  // One random instruction, or in half of the cases a short sequence of them.
  task automatic random_instruction();
    op_t opc;
    logic [LID_W-1:0] lid;
    logic [POS_W-1:0] pos;
    logic [WORD_W-1:0] junk;
    lid = LID_W'($urandom_range(255));
    pos = POS_W'($urandom);
    junk = {$urandom, $urandom};
    case ($urandom_range(9))
      0: begin
        send_instruction(OP_PUSH, rand_address(), lid, pos, junk);
        send_instruction(OP_PUSH, rand_word(), lid, pos, junk);
        send_instruction(OP_STORE, junk, lid, pos, junk);
      end
      1: begin
        send_instruction(OP_PUSH, rand_address(), lid, pos, junk);
        send_instruction(OP_RETRIEVE, junk, lid, pos, junk);
      end
      2: begin
        send_instruction(OP_LABEL, junk, lid, pos, junk);
        send_instruction($urandom_range(1) ? OP_CALL : OP_JMP, junk, lid, pos, junk);
      end
      3: begin
        send_instruction(OP_PUSH, rand_word(), lid, pos, junk);
        send_instruction(OP_PUSH, rand_word(), lid, pos, junk);
        opc = op_t'($urandom_range(OP_ADD, OP_MOD));
        send_instruction(opc, junk, lid, pos, junk);
      end
      4: begin
        // Drain deep stacks now and then so both overflow and underflow occur.
        repeat ($urandom_range(1, 8))
          send_instruction(OP_PRINTI, junk, lid, pos, junk);
      end
      default: begin
        opc = op_t'($urandom_range(31));
        send_instruction(opc, rand_word(), lid, pos, rand_word());
      end
    endcase
  endtask

  task automatic directed_sequence();
    send_instruction(OP_DROP, '0, '0, '0, '0);
    send_instruction(OP_RET, '0, '0, '0, '0);
    send_instruction(OP_PUSH, 64'h8000_0000_0000_0000, 8'hFF, 12'hFFF, '1);
    send_instruction(OP_PUSH, '1, '0, '0, '0);
    send_instruction(OP_DIV, '0, '0, '0, '0);
    send_instruction(OP_DUP, '0, '0, '0, '0);
    send_instruction(OP_PUSH, '0, '0, '0, '0);
    send_instruction(OP_MOD, '0, '0, '0, '0);
    send_instruction(OP_READI, '0, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_instruction(OP_READC, '0, '0, '0, 64'h41);
    send_instruction(OP_SWAP, '0, '0, '0, '0);
    send_instruction(OP_PRINTC, '0, '0, '0, '0);
    send_instruction(OP_PRINTI, '0, '0, '0, '0);
    send_instruction(OP_LABEL, '0, 8'hFF, 12'hFFF, '0);
    send_instruction(OP_CALL, '0, 8'hFF, '0, '0);
    send_instruction(OP_JN, '0, 8'hFF, '0, '0);
    send_instruction(OP_PUSH, '0, '0, '0, '0);
    send_instruction(OP_JZ, '0, 8'hFF, '0, '0);
    send_instruction(OP_RET, '0, '0, '0, '0);
    send_instruction(OP_PUSH, '1, '0, '0, '0);
    send_instruction(OP_RETRIEVE, '0, '0, '0, '0);
    send_instruction(OP_END, '0, '0, '0, '0);
    send_instruction(op_t'(5'd31), '0, '0, '0, '0);
    repeat (DEF_CALL_DEPTH + 1) send_instruction(OP_CALL, '0, 8'd3, '0, '0);
    repeat (DEF_STACK_DEPTH + 1) send_instruction(OP_DUP, '0, '0, '0, '0);
  endtask

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int drain;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.immediate = '0;
    in_ch.label_id = '0;
    in_ch.position = '0;
    in_ch.read_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.program_length = '0;
    board = new();
    sent = 0;
    send_idle_pct = 14;
    recv_idle_pct = 61;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_length(13'd4096);
    directed_sequence();
    while (sent < 400) random_instruction();
    write_length(13'd0);
    send_idle_pct = 61;
    recv_idle_pct = 14;
    hold_req++;
    while (sent < 800) random_instruction();
    write_length(13'd4095);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sent < 1000) random_instruction();
    write_length(PC_W'($urandom_range(4096)));
    while (sent < 1150) random_instruction();
    in_ch.valid <= 1'b0;
    drain = 0;
    while (board.pending.size() != 0 && drain < 100000) begin
      @(negedge clk);
      drain++;
    end
    repeat (100) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/sme_pkg.sv
hw/rtl/sme_if.sv
hw/rtl/sme_ram.sv
hw/rtl/sme_md.sv
hw/rtl/sme_dp.sv
hw/rtl/sme_ctrl.sv
hw/rtl/stack_machine_executor.sv
sim/tb_stack_machine_executor.sv
